// File: design/bblru_pkg.sv
// package: types, constants and codes for the byte-budget lru directory
package bblru_pkg;

   localparam int unsigned SLOTS_DEFAULT = 32;
   localparam logic [31:0] BYTE_CAPACITY_RESET = 32'd16777216;
   localparam logic [23:0] VALUE_CAP_RESET = 24'd4194304;

   localparam int unsigned KEY_W = 64;
   localparam int unsigned LEN_W = 24;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_FILL   = 2'd2;
   localparam logic [1:0] CMD_BAD    = 2'd3;

   localparam logic [2:0] ST_HIT     = 3'd0;
   localparam logic [2:0] ST_MISS    = 3'd1;
   localparam logic [2:0] ST_ADDED   = 3'd2;
   localparam logic [2:0] ST_PRESENT = 3'd3;
   localparam logic [2:0] ST_REJECT  = 3'd4;
   localparam logic [2:0] ST_EVICTED = 3'd5;

   localparam logic REG_BYTE_CAPACITY = 1'b0;
   localparam logic REG_VALUE_CAP     = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_TOUCH,
      S_VICTIM,
      S_EVICT,
      S_ADD,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] length;
      logic             last;
   } result_type;

endpackage

// File: design/bblru_ram.sv
// generic single-port-write ram with a registered read
module bblru_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: design/bblru_out.sv
// output register: holds one result word until the consumer takes it
module bblru_out
   import bblru_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);
   logic       valid_ff, valid_in;
   result_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (push) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (push) begin
         data_ff <= push_data;
      end
   end

   // a push is allowed when the register is empty or draining this cycle
   assign full      = valid_ff && rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule

// File: design/byte_budget_lru_cache_directory.sv
// Directory of a size-aware lru cache: one command per word; a key search and a
// recency update each walk every slot, one slot a cycle, through the slot memories
// (single read port, registered read). After a word is accepted req_stall stays high
// until the command's final result word is pushed; a miss, a rejected command or a
// fill of a present key takes the search walk only, a hit or an insert of a present
// key adds a recency walk, and an add runs an ageing walk after one victim walk per
// eviction; each stall of a pending word by the result side extends the wait.
// Each eviction is its own result word before the final one. Slot
// valid bits are flip-flops cleared by reset, so no clearing pass is needed.
module byte_budget_lru_cache_directory
   import bblru_pkg::*;
#(
   parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_command,
   input  logic [63:0]             req_key,
   input  logic [23:0]             req_length,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [63:0]             rsp_key_out,
   output logic [23:0]             rsp_length_out,
   output logic                    rsp_last,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_index,
   input  logic [31:0]             csr_data
);
   localparam int unsigned AW = $clog2(SLOTS);
   localparam int unsigned CW = $clog2(SLOTS + 1);
   localparam int unsigned EW = KEY_W + LEN_W;
   localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(SLOTS);
   localparam logic [1:0] TMODE_TOUCH = 2'd0;
   localparam logic [1:0] TMODE_AGE   = 2'd1;

   state_type state_ff, state_in;

   logic [31:0] cap_ff;
   logic [23:0] vcap_ff;
   logic [31:0] bytes_ff, bytes_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [CW-1:0] count_ff, count_in;

   logic [1:0]  cmd_ff;
   logic [63:0] key_ff;
   logic [23:0] len_ff;

   // walk control: the compared slot pointer is a registered copy of the read address
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] cmp_ptr_ff, cmp_ptr_in;
   logic          cmp_ok_ff, cmp_ok_in;
   logic          found_ff, found_in;
   logic [AW-1:0] found_idx_ff, found_idx_in;
   logic [AW-1:0] found_rank_ff, found_rank_in;
   logic [23:0]   found_len_ff, found_len_in;
   logic [AW-1:0] vic_ff, vic_in;
   logic [AW-1:0] vic_rank_ff, vic_rank_in;
   logic          vic_any_ff, vic_any_in;
   logic [1:0]    tmode_ff, tmode_in;  // touch found, or age all and add
   logic [AW-1:0] free_ff;

   logic [EW-1:0] ent_wdata, ent_rdata;
   logic          ent_we;
   logic [AW-1:0] ent_waddr, ent_raddr;
   logic [AW-1:0] rank_wdata, rank_rdata;
   logic          rank_we;
   logic [AW-1:0] rank_waddr;

   logic [KEY_W-1:0] rd_key;
   logic [LEN_W-1:0] rd_len;

   logic       push, out_full;
   result_type push_data, out_data;

   // final word held across the reply wait
   result_type reply_ff;
   result_type reply_data;
   assign reply_data = (state_ff == S_REPLY) ? reply_ff : push_data;

   bblru_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ent (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_waddr), .wr_data(ent_wdata),
      .rd_addr(ent_raddr), .rd_data(ent_rdata)
   );
   bblru_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_rank (
      .clock(clock), .wr_en(rank_we), .wr_addr(rank_waddr), .wr_data(rank_wdata),
      .rd_addr(ent_raddr), .rd_data(rank_rdata)
   );

   bblru_out u_out (
      .clock(clock), .reset(reset), .push(push), .push_data(reply_data),
      .full(out_full), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(out_data)
   );

   assign rsp_status     = out_data.status;
   assign rsp_key_out    = out_data.key;
   assign rsp_length_out = out_data.length;
   assign rsp_last       = out_data.last;

   assign rd_key = ent_rdata[EW-1 -: KEY_W];
   assign rd_len = ent_rdata[LEN_W-1:0];

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign ent_raddr = rd_ptr_ff;

   logic accept;
   assign accept = req_valid && (state_ff == S_IDLE);

   logic [32:0] need;
   assign need = {1'b0, bytes_ff} + {9'd0, len_ff};

   always_comb begin
      state_in      = state_ff;
      bytes_in      = bytes_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      cmp_ptr_in    = cmp_ptr_ff;
      cmp_ok_in     = 1'b0;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_rank_in = found_rank_ff;
      found_len_in  = found_len_ff;
      vic_in        = vic_ff;
      vic_rank_in   = vic_rank_ff;
      vic_any_in    = vic_any_ff;
      tmode_in      = tmode_ff;
      ent_we        = 1'b0;
      ent_waddr     = free_ff;
      ent_wdata     = {key_ff, len_ff};
      rank_we       = 1'b0;
      rank_waddr    = cmp_ptr_ff;
      rank_wdata    = '0;
      push          = 1'b0;
      push_data     = '{status: ST_REJECT, key: key_ff, length: '0, last: 1'b1};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rd_ptr_in = '0;
               found_in  = 1'b0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            // search for the key
            if (cmp_ok_ff && valid_ff[cmp_ptr_ff] && rd_key == key_ff) begin
               found_in      = 1'b1;
               found_idx_in  = cmp_ptr_ff;
               found_rank_in = rank_rdata;
               found_len_in  = rd_len;
            end
            cmp_ptr_in = rd_ptr_ff;
            if (cmp_ok_ff && cmp_ptr_ff == LAST_SLOT) begin
               state_in = S_DECIDE;
            end else begin
               cmp_ok_in = (cmp_ptr_ff != LAST_SLOT) || !cmp_ok_ff;
               if (rd_ptr_ff != LAST_SLOT) begin
                  rd_ptr_in = rd_ptr_ff + AW'(1);
               end
               if (!cmp_ok_ff) begin
                  cmp_ok_in = 1'b1;
               end
            end
         end
         S_DECIDE: begin
            rd_ptr_in = '0;
            if (cmd_ff == CMD_LOOKUP) begin
               if (found_ff) begin
                  tmode_in = TMODE_TOUCH;
                  state_in = S_TOUCH;
               end else begin
                  push_data = '{status: ST_MISS, key: key_ff, length: '0, last: 1'b1};
                  state_in  = S_REPLY;
               end
            end else if (cmd_ff != CMD_INSERT && cmd_ff != CMD_FILL
                         || len_ff == '0 || len_ff > vcap_ff) begin
               push_data = '{status: ST_REJECT, key: key_ff, length: '0, last: 1'b1};
               state_in  = S_REPLY;
            end else if (found_ff) begin
               push_data = '{status: ST_PRESENT, key: key_ff, length: '0, last: 1'b1};
               if (cmd_ff == CMD_INSERT) begin
                  tmode_in = TMODE_TOUCH;
                  state_in = S_TOUCH;
               end else begin
                  state_in = S_REPLY;
               end
            end else if (count_ff != '0
                         && (need > {1'b0, cap_ff} || count_ff == FULL_CNT)) begin
               vic_any_in = 1'b0;
               state_in   = S_VICTIM;
            end else begin
               tmode_in = TMODE_AGE;
               state_in = S_TOUCH;
            end
            cmp_ok_in = 1'b0;
         end
         S_TOUCH: begin
            // rank update walk; free_ff tracks the lowest free slot in every state but S_ADD
            if (cmp_ok_ff) begin
               if (tmode_ff == TMODE_TOUCH) begin
                  if (cmp_ptr_ff == found_idx_ff) begin
                     rank_we = 1'b1;
                  end else if (valid_ff[cmp_ptr_ff] && rank_rdata < found_rank_ff) begin
                     rank_we    = 1'b1;
                     rank_wdata = rank_rdata + AW'(1);
                  end
               end else if (valid_ff[cmp_ptr_ff]) begin
                  rank_we    = 1'b1;
                  rank_wdata = rank_rdata + AW'(1);
               end
            end
            cmp_ptr_in = rd_ptr_ff;
            if (cmp_ok_ff && cmp_ptr_ff == LAST_SLOT) begin
               if (tmode_ff == TMODE_TOUCH) begin
                  if (cmd_ff == CMD_LOOKUP) begin
                     push_data = '{status: ST_HIT, key: key_ff, length: found_len_ff,
                                   last: 1'b1};
                  end else begin
                     push_data = '{status: ST_PRESENT, key: key_ff, length: '0,
                                   last: 1'b1};
                  end
                  state_in = S_REPLY;
               end else begin
                  state_in = S_ADD;
               end
            end else begin
               cmp_ok_in = 1'b1;
               if (rd_ptr_ff != LAST_SLOT) begin
                  rd_ptr_in = rd_ptr_ff + AW'(1);
               end
            end
         end
         S_VICTIM: begin
            // oldest valid slot: largest rank
            if (cmp_ok_ff && valid_ff[cmp_ptr_ff]
                && (!vic_any_ff || rank_rdata > vic_rank_ff)) begin
               vic_any_in  = 1'b1;
               vic_in      = cmp_ptr_ff;
               vic_rank_in = rank_rdata;
            end
            cmp_ptr_in = rd_ptr_ff;
            if (cmp_ok_ff && cmp_ptr_ff == LAST_SLOT) begin
               rd_ptr_in = vic_in;
               state_in  = S_EVICT;
               cmp_ok_in = 1'b0;
            end else begin
               cmp_ok_in = 1'b1;
               if (rd_ptr_ff != LAST_SLOT) begin
                  rd_ptr_in = rd_ptr_ff + AW'(1);
               end
            end
         end
         S_EVICT: begin
            // read the victim entry first, then report it once the output register can take it
            if (!cmp_ok_ff) begin
               cmp_ok_in = 1'b1;
            end else if (!out_full) begin
               push      = 1'b1;
               push_data = '{status: ST_EVICTED, key: rd_key, length: rd_len, last: 1'b0};
               valid_in[vic_ff] = 1'b0;
               count_in  = count_ff - CW'(1);
               bytes_in  = (bytes_ff >= {8'd0, rd_len}) ? bytes_ff - {8'd0, rd_len} : '0;
               rd_ptr_in = '0;
               state_in  = S_DECIDE;
            end else begin
               cmp_ok_in = 1'b1;
            end
         end
         S_ADD: begin
            ent_we     = 1'b1;
            rank_we    = 1'b1;
            rank_waddr = free_ff;
            valid_in[free_ff] = 1'b1;
            count_in   = count_ff + CW'(1);
            bytes_in   = bytes_ff + {8'd0, len_ff};
            push_data  = '{status: ST_ADDED, key: key_ff, length: '0, last: 1'b1};
            state_in   = S_REPLY;
         end
         S_REPLY: begin
            if (!out_full) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   logic [AW-1:0] free_pick;
   always_comb begin
      free_pick = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_pick = AW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cap_ff   <= BYTE_CAPACITY_RESET;
         vcap_ff  <= VALUE_CAP_RESET;
         bytes_ff <= '0;
         valid_ff <= '0;
         count_ff <= '0;
         cmp_ok_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         bytes_ff  <= bytes_in;
         valid_ff  <= valid_in;
         count_ff  <= count_in;
         cmp_ok_ff <= cmp_ok_in;
         if (csr_valid) begin
            if (csr_index == REG_BYTE_CAPACITY) begin
               cap_ff <= csr_data;
            end else begin
               vcap_ff <= csr_data[23:0];
            end
         end
      end
      if (accept) begin
         cmd_ff <= req_command;
         key_ff <= req_key;
         len_ff <= req_length;
      end
      rd_ptr_ff     <= rd_ptr_in;
      cmp_ptr_ff    <= cmp_ptr_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_rank_ff <= found_rank_in;
      found_len_ff  <= found_len_in;
      vic_ff        <= vic_in;
      vic_rank_ff   <= vic_rank_in;
      vic_any_ff    <= vic_any_in;
      tmode_ff      <= tmode_in;
      free_ff       <= (state_ff == S_ADD) ? free_ff : free_pick;
      if (state_in == S_REPLY && state_ff != S_REPLY) begin
         reply_ff <= push_data;
      end
   end
endmodule
